[hdl/tape_machine_instruction_execute_macros.svh]
// ---------------------------------------------------------------------------
// Tape machine instruction execute: assertion macros
// Shared concurrent assertion forms for the checker of the execute stage.
// ---------------------------------------------------------------------------
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define TMIE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define TMIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define TMIE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/tmie_pkg.sv]
// ---------------------------------------------------------------------------
// Tape machine instruction execute: package
// Opcodes, field widths and bus layouts shared by the RTL and its checker.
// ---------------------------------------------------------------------------
package tmie_pkg;

   localparam int unsigned TAPE_DEPTH_DEFAULT = 32768;

   localparam int unsigned ACTION_WIDTH    = 4;
   localparam int unsigned PC_WIDTH        = 15;
   localparam int unsigned NEXT_PC_WIDTH   = 16;
   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned REQ_TDATA_WIDTH = 48;
   localparam int unsigned RSP_TDATA_WIDTH = 24;

   // Result queue behind the execute stage.
   localparam int unsigned Q_DEPTH     = 4;
   localparam int unsigned Q_PTR_WIDTH = 2;
   localparam int unsigned Q_CNT_WIDTH = 3;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_RIGHT = 4'd0,
      ACT_LEFT  = 4'd1,
      ACT_INC   = 4'd2,
      ACT_DEC   = 4'd3,
      ACT_OUT   = 4'd4,
      ACT_IN    = 4'd5,
      ACT_OPEN  = 4'd6,
      ACT_CLOSE = 4'd7,
      ACT_CLEAR = 4'd8,
      ACT_ADD   = 4'd9,
      ACT_SUB   = 4'd10
   } action_type;

   typedef enum logic {
      ST_CLEAR = 1'b0,
      ST_RUN   = 1'b1
   } state_type;

   // Instruction held in the execute stage.
   typedef struct packed {
      action_type            action;
      logic [PC_WIDTH-1:0]   pc;
      logic [PC_WIDTH-1:0]   target;
      logic [BYTE_WIDTH-1:0] amount;
      logic [BYTE_WIDTH-1:0] in_byte;
   } instr_type;

   // One result waiting in the output queue.
   typedef struct packed {
      logic [NEXT_PC_WIDTH-1:0] next_pc;
      logic                     out_valid;
      logic [BYTE_WIDTH-1:0]    out_byte;
   } result_type;

endpackage

[hdl/tape_machine_instruction_execute.sv]
// ---------------------------------------------------------------------------
// Tape machine instruction execute
// Execute stage of a byte-tape machine: one instruction per transfer against
// a tape of byte cells in a synchronous RAM and a data pointer register.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit first)                        | tuser
//  --------+-----------+----------------------------------------------+-----------
//  req     | in        | pc, match_target, amount, in_byte, 2'b0 pad  | action
//  rsp     | out       | next_pc, out_byte                            | out_valid
//
//  After reset the tape is swept to zero, one cell per cycle; req_tready
//  stays low during that sweep.
//  An accepted instruction reads its cell in the cycle of the transfer and is
//  executed in the next cycle; its result then goes into the result queue
//  and is offered from there. One instruction is accepted per cycle while
//  req_tready is high; the tape RAM port sets it.
//  A write to a cell is forwarded to the instruction right behind it, so
//  back-to-back instructions on the same cell need no bubble.
//  Results go through a four-entry queue; req_tready drops only when that
//  queue and the instruction in execute already take all four entries.
//
module tape_machine_instruction_execute #(
   parameter int unsigned TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // pc[14:0], match_target[29:15], amount[37:30], in_byte[45:38], zero[47:46]
   input  logic [tmie_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // action[3:0]
   input  logic [tmie_pkg::ACTION_WIDTH-1:0]    req_tuser,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // next_pc[15:0], out_byte[23:16]
   output logic [tmie_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // out_valid[0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);

   import tmie_pkg::*;

   localparam int unsigned DP_WIDTH = $clog2(TAPE_DEPTH);
   localparam logic [DP_WIDTH-1:0] DP_LAST = DP_WIDTH'(TAPE_DEPTH - 1);

   // Control state: clearing sweep, then normal operation.
   state_type           state_ff, state_in;
   logic [DP_WIDTH-1:0] clr_addr_ff, clr_addr_in;
   logic                clearing;

   // Data pointer.
   logic [DP_WIDTH-1:0] dp_ff, dp_in;

   // Execute stage.
   logic                s1_valid_ff, s1_valid_in;
   instr_type           s1_ff, s1_in;
   logic [DP_WIDTH-1:0] s1_addr_ff;

   // Tape RAM.
   logic [BYTE_WIDTH-1:0] tape_mem [TAPE_DEPTH];
   logic [BYTE_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic [DP_WIDTH-1:0]   mem_waddr;
   logic [BYTE_WIDTH-1:0] mem_wdata;

   // Forwarding of the write that lands on the same edge as the next read.
   logic                  fwd_valid_ff, fwd_valid_in;
   logic [DP_WIDTH-1:0]   fwd_addr_ff;
   logic [BYTE_WIDTH-1:0] fwd_data_ff;

   // Execute results.
   logic [BYTE_WIDTH-1:0] cell_val;
   logic                  ex_we;
   logic [BYTE_WIDTH-1:0] ex_wdata;
   result_type            ex_result;

   // Result queue.
   result_type             q_mem [Q_DEPTH];
   logic [Q_PTR_WIDTH-1:0] q_wr_ptr_ff, q_wr_ptr_in;
   logic [Q_PTR_WIDTH-1:0] q_rd_ptr_ff, q_rd_ptr_in;
   logic [Q_CNT_WIDTH-1:0] q_count_ff, q_count_in;
   logic                   q_push;
   logic                   q_pop;
   logic                   q_has_room;
   result_type             q_head;

   logic req_accept;

   // ------------------------------------------------------------------------
   // Control state machine. The sweep writes zero into every cell once.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The queue may take a new instruction when the queue, the instruction in
   // execute and the new one all fit.
   assign q_has_room = (q_count_ff + Q_CNT_WIDTH'(s1_valid_ff)) < Q_CNT_WIDTH'(Q_DEPTH);

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      clearing    = 1'b0;
      req_tready  = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clearing    = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == DP_LAST) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            req_tready = q_has_room;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign req_accept = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // Accept: unpack the transfer and move the data pointer. The pointer move
   // never depends on the cell, so it is settled here.
   // ------------------------------------------------------------------------
   always_comb begin
      s1_in.action  = action_type'(req_tuser);
      s1_in.pc      = req_tdata[14:0];
      s1_in.target  = req_tdata[29:15];
      s1_in.amount  = req_tdata[37:30];
      s1_in.in_byte = req_tdata[45:38];
      s1_valid_in   = req_accept;

      dp_in = dp_ff;
      if (req_accept) begin
         unique case (s1_in.action)
            ACT_RIGHT: dp_in = (dp_ff == DP_LAST) ? '0 : dp_ff + 1'b1;
            ACT_LEFT:  dp_in = (dp_ff == '0) ? DP_LAST : dp_ff - 1'b1;
            default:   dp_in = dp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dp_ff        <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         dp_ff        <= dp_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s1_addr_ff  <= dp_ff;
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= ex_wdata;
   end

   // ------------------------------------------------------------------------
   // Tape RAM: one write port, one registered read port at the pointer.
   // ------------------------------------------------------------------------
   assign mem_we    = clearing || (s1_valid_ff && ex_we);
   assign mem_waddr = clearing ? clr_addr_ff : s1_addr_ff;
   assign mem_wdata = clearing ? '0 : ex_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         tape_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= tape_mem[dp_ff];
   end

   // ------------------------------------------------------------------------
   // Execute. The read was taken on the same edge as the previous write, so
   // a write to the same cell on that edge overrides the RAM data.
   // ------------------------------------------------------------------------
   assign fwd_valid_in = s1_valid_ff && ex_we;
   assign cell_val = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : rd_data_ff;

   always_comb begin
      ex_we               = 1'b0;
      ex_wdata            = cell_val;
      ex_result.next_pc   = {1'b0, s1_ff.pc} + 1'b1;
      ex_result.out_valid = 1'b0;
      ex_result.out_byte  = '0;
      unique case (s1_ff.action)
         ACT_INC: begin
            ex_we    = 1'b1;
            ex_wdata = cell_val + 1'b1;
         end
         ACT_DEC: begin
            ex_we    = 1'b1;
            ex_wdata = cell_val - 1'b1;
         end
         ACT_OUT: begin
            ex_result.out_valid = 1'b1;
            ex_result.out_byte  = cell_val;
         end
         ACT_IN: begin
            ex_we    = 1'b1;
            ex_wdata = s1_ff.in_byte;
         end
         ACT_OPEN: begin
            if (cell_val == '0) begin
               ex_result.next_pc = {1'b0, s1_ff.target} + 1'b1;
            end
         end
         ACT_CLOSE: begin
            if (cell_val != '0) begin
               ex_result.next_pc = {1'b0, s1_ff.target} + 1'b1;
            end
         end
         ACT_CLEAR: begin
            ex_we    = 1'b1;
            ex_wdata = '0;
         end
         ACT_ADD: begin
            ex_we             = 1'b1;
            ex_wdata          = cell_val + s1_ff.amount;
            ex_result.next_pc = {1'b0, s1_ff.pc} + 2'd2;
         end
         ACT_SUB: begin
            ex_we             = 1'b1;
            ex_wdata          = cell_val - s1_ff.amount;
            ex_result.next_pc = {1'b0, s1_ff.pc} + 2'd2;
         end
         default: begin
            // Pointer moves and unused codes leave the tape alone.
            ex_we = 1'b0;
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Result queue. Room is reserved at accept, so a push always fits.
   // ------------------------------------------------------------------------
   assign q_push     = s1_valid_ff;
   assign q_pop      = rsp_tvalid && rsp_tready;
   assign q_head     = q_mem[q_rd_ptr_ff];
   assign rsp_tvalid = (q_count_ff != '0);
   assign rsp_tdata  = {q_head.out_byte, q_head.next_pc};
   assign rsp_tuser  = q_head.out_valid;

   always_comb begin
      q_wr_ptr_in = q_push ? q_wr_ptr_ff + 1'b1 : q_wr_ptr_ff;
      q_rd_ptr_in = q_pop ? q_rd_ptr_ff + 1'b1 : q_rd_ptr_ff;
      case ({q_push, q_pop})
         2'b10:   q_count_in = q_count_ff + 1'b1;
         2'b01:   q_count_in = q_count_ff - 1'b1;
         default: q_count_in = q_count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         q_wr_ptr_ff <= q_wr_ptr_in;
         q_rd_ptr_ff <= q_rd_ptr_in;
         q_count_ff  <= q_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[q_wr_ptr_ff] <= ex_result;
      end
   end

endmodule

[hdl/tmie_checker.sv]
// ---------------------------------------------------------------------------
// Tape machine instruction execute: port checker
// Watches the ports of the execute stage and flags misbehavior over time.
// ---------------------------------------------------------------------------
`include "tape_machine_instruction_execute_macros.svh"

module tmie_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic [tmie_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   input logic [tmie_pkg::ACTION_WIDTH-1:0]    req_tuser,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic [tmie_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic                                 rsp_tuser,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready
);

   import tmie_pkg::*;

   // The tape sweep follows reset, so no instruction may be taken right after.
   `TMIE_ASSERT_NEXT_ALWAYS(a_no_accept_after_reset, clock, reset, !req_tready, "req_tready high right after reset")

   // A result that is not an output transfer carries a zero byte.
   `TMIE_ASSERT_IMPLY(a_byte_zero_without_output, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[23:16] == '0, "out_byte nonzero without out_valid")

   // Every next program index is at least one past some instruction index.
   `TMIE_ASSERT_IMPLY(a_next_pc_nonzero, clock, reset, rsp_tvalid, rsp_tdata[15:0] != '0, "next_pc of zero")

   // A stalled result stays in place.
   `TMIE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

endmodule

bind tape_machine_instruction_execute tmie_checker u_tmie_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

[test/tb.sv]
// ---------------------------------------------------------------------------
// Tape machine instruction execute: testbench
// Drives instructions into the execute stage and predicts each result from a
// private copy of the tape and the data pointer. Every result transfer is
// checked field by field against the oldest prediction. Directed cases cover
// pointer wrap, cell wrap, loop jumps and unused opcodes. Random program walks
// follow, under three patterns of sender and receiver idling.
// ---------------------------------------------------------------------------
module tb;
   import tmie_pkg::*;

   // The block is built with its default tape, so the model uses the same size.
   localparam int unsigned TAPE_CELLS = TAPE_DEPTH_DEFAULT;
   localparam int unsigned DP_WIDTH   = $clog2(TAPE_CELLS);
   localparam int unsigned OP_LAST    = (1 << ACTION_WIDTH) - 1;
   // A result passes the execute stage and then the output queue before it can leave.
   localparam int unsigned DRAIN_CYCLES = 12;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata  = '0;
   logic [ACTION_WIDTH-1:0]    req_tuser  = '0;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tuser;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;

   // Chance in percent that the sender holds back or the receiver stalls.
   int unsigned send_idle_pct = 7;
   int unsigned recv_idle_pct = 84;
   int unsigned err_count     = 0;

   // Private copy of the machine state used for prediction.
   logic [BYTE_WIDTH-1:0]    tape_model [TAPE_CELLS];
   logic [DP_WIDTH-1:0]      data_ptr = '0;
   logic [NEXT_PC_WIDTH-1:0] last_next_pc = '0;

   // Results that have been predicted but not yet seen on the result channel.
   result_type expected_results [$];
   result_type want;

   tape_machine_instruction_execute u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Executes one instruction against the private state and returns the
   // result the block should give for it.
   function automatic result_type execute_instruction(
      input logic [ACTION_WIDTH-1:0] act,
      input logic [PC_WIDTH-1:0]     pc,
      input logic [PC_WIDTH-1:0]     target,
      input logic [BYTE_WIDTH-1:0]   amount,
      input logic [BYTE_WIDTH-1:0]   in_byte
   );
      result_type            res;
      logic [BYTE_WIDTH-1:0] cell_val;
      cell_val      = tape_model[data_ptr];
      res.next_pc   = {1'b0, pc} + 16'd1;
      res.out_valid = 1'b0;
      res.out_byte  = '0;
      case (act)
         ACT_RIGHT: data_ptr = (data_ptr == TAPE_CELLS - 1) ? '0 : data_ptr + 1'b1;
         ACT_LEFT:  data_ptr = (data_ptr == 0) ? DP_WIDTH'(TAPE_CELLS - 1) : data_ptr - 1'b1;
         ACT_INC:   tape_model[data_ptr] = cell_val + 1'b1;
         ACT_DEC:   tape_model[data_ptr] = cell_val - 1'b1;
         ACT_OUT: begin
            res.out_valid = 1'b1;
            res.out_byte  = cell_val;
         end
         ACT_IN:    tape_model[data_ptr] = in_byte;
         // A loop open skips the body when the cell is zero; a loop close goes
         // back to the body while the cell is nonzero.
         ACT_OPEN:  if (cell_val == 0) res.next_pc = {1'b0, target} + 16'd1;
         ACT_CLOSE: if (cell_val != 0) res.next_pc = {1'b0, target} + 16'd1;
         ACT_CLEAR: tape_model[data_ptr] = '0;
         // The amount takes up its own program slot, so the program skips it.
         ACT_ADD: begin
            tape_model[data_ptr] = cell_val + amount;
            res.next_pc = {1'b0, pc} + 16'd2;
         end
         ACT_SUB: begin
            tape_model[data_ptr] = cell_val - amount;
            res.next_pc = {1'b0, pc} + 16'd2;
         end
         default: ;
      endcase
      last_next_pc = res.next_pc;
      return res;
   endfunction

   // Offers one instruction and holds it until the transfer happens. The
   // prediction is made at the edge of the transfer. The valid stays high
   // into the next call, so back-to-back transfers need no bubble.
   task automatic send_instr(
      input logic [ACTION_WIDTH-1:0] act,
      input logic [PC_WIDTH-1:0]     pc,
      input logic [PC_WIDTH-1:0]     target,
      input logic [BYTE_WIDTH-1:0]   amount,
      input logic [BYTE_WIDTH-1:0]   in_byte
   );
      result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {2'b00, in_byte, amount, target, pc};
      do @(posedge clock); while (!req_tready);
      pred = execute_instruction(act, pc, target, amount, in_byte);
      expected_results = {expected_results, pred};
   endtask

   // The receiver stalls at random; the rate changes between phases.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every result transfer is matched against the oldest prediction. Values
   // are sampled at the edge, before the block updates them.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result transfer with no prediction waiting: tdata %h tuser %b",
                   rsp_tdata, rsp_tuser);
            err_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[15:0] !== want.next_pc) begin
               $error("next_pc: expected %0d, got %0d", want.next_pc, rsp_tdata[15:0]);
               err_count++;
            end
            if (rsp_tuser !== want.out_valid) begin
               $error("out_valid: expected %0d, got %0d", want.out_valid, rsp_tuser);
               err_count++;
            end
            if (rsp_tdata[23:16] !== want.out_byte) begin
               $error("out_byte: expected %0d, got %0d", want.out_byte, rsp_tdata[23:16]);
               err_count++;
            end
         end
      end
   end

   // The pointer starts at cell zero, so one step left lands on the last cell
   // and one step right comes back.
   task automatic test_pointer_wrap();
      send_instr(ACT_LEFT,  15'd0,     15'd0,     8'h00, 8'h00);
      send_instr(ACT_IN,    15'd1,     15'd0,     8'h00, 8'hFF);
      send_instr(ACT_OUT,   15'd2,     15'h7FFF,  8'hFF, 8'h00);
      send_instr(ACT_RIGHT, 15'd3,     15'd0,     8'h00, 8'h00);
      send_instr(ACT_OUT,   15'd4,     15'd0,     8'h00, 8'hFF);
   endtask

   // Cell arithmetic wraps in both directions; the largest program index shows
   // next_pc going past fifteen bits.
   task automatic test_cell_arithmetic();
      send_instr(ACT_DEC,   15'd5,     15'd0,     8'h00, 8'h00);
      send_instr(ACT_INC,   15'd6,     15'd0,     8'h00, 8'h00);
      send_instr(ACT_ADD,   15'h7FFF,  15'd0,     8'hFF, 8'h00);
      send_instr(ACT_SUB,   15'h7FFE,  15'd0,     8'hFF, 8'h00);
      send_instr(ACT_ADD,   15'd9,     15'd0,     8'h80, 8'h00);
      send_instr(ACT_CLEAR, 15'd11,    15'd0,     8'h00, 8'h00);
      send_instr(ACT_OUT,   15'h7FFF,  15'd0,     8'h00, 8'h00);
   endtask

   // Both bracket kinds, each with the jump taken and not taken.
   task automatic test_loops();
      send_instr(ACT_OPEN,  15'd12,    15'h7FFF,  8'h00, 8'h00);
      send_instr(ACT_CLOSE, 15'd13,    15'd0,     8'h00, 8'h00);
      send_instr(ACT_INC,   15'd14,    15'd0,     8'h00, 8'h00);
      send_instr(ACT_OPEN,  15'd15,    15'h7FFF,  8'h00, 8'h00);
      send_instr(ACT_CLOSE, 15'd16,    15'd0,     8'h00, 8'h00);
      send_instr(ACT_CLEAR, 15'd17,    15'd0,     8'h00, 8'h00);
   endtask

   // Opcodes past the last defined one only advance the program index.
   task automatic test_unused_opcodes();
      for (int op = int'(ACT_SUB) + 1; op <= OP_LAST; op++) begin
         send_instr(op[ACTION_WIDTH-1:0], 15'd18, 15'h7FFF, 8'hFF, 8'hFF);
      end
   endtask

   // Random programs: the program index mostly follows the predicted next_pc,
   // as a fetch stage would, with occasional jumps elsewhere. Moves are rare
   // enough that the pointer wanders around cell zero and wraps often, and
   // most instructions hit the same cell as the one before them.
   task automatic test_random_program(input int unsigned count);
      logic [ACTION_WIDTH-1:0] act;
      logic [PC_WIDTH-1:0]     pc;
      int unsigned             roll;
      for (int unsigned i = 0; i < count; i++) begin
         roll = $urandom_range(99);
         if (roll < 3)
            act = ACTION_WIDTH'($urandom_range(OP_LAST, int'(ACT_SUB) + 1));
         else
            act = ACTION_WIDTH'($urandom_range(int'(ACT_SUB)));
         if ($urandom_range(9) == 0)
            pc = PC_WIDTH'($urandom_range(15'h7FFF));
         else
            pc = last_next_pc[PC_WIDTH-1:0];
         send_instr(act, pc, PC_WIDTH'($urandom_range(15'h7FFF)),
                    BYTE_WIDTH'($urandom_range(8'hFF)),
                    BYTE_WIDTH'($urandom_range(8'hFF)));
      end
   endtask

   initial begin
      for (int unsigned i = 0; i < TAPE_CELLS; i++) tape_model[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its tape after reset; the first transfer simply
      // waits for req_tready.
      test_pointer_wrap();
      test_cell_arithmetic();
      test_loops();
      test_unused_opcodes();
      test_random_program(360);

      send_idle_pct = 84;
      recv_idle_pct = 7;
      test_random_program(360);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_program(360);

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Guard against a hang: the slowest correct run is far shorter.
   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[tape_machine_instruction_execute.f]
+incdir+hdl
hdl/tmie_pkg.sv
hdl/tape_machine_instruction_execute.sv
hdl/tmie_checker.sv
test/tb.sv
